// File: rtl/core/line_normal_and_distance_unit_macros.svh
// ============================================================================
// Line normal unit assertion macros
// Wrappers for the concurrent checks of the line normal unit.
// ============================================================================
`ifndef LINE_NORMAL_AND_DISTANCE_UNIT_MACROS_SVH
`define LINE_NORMAL_AND_DISTANCE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LND_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lnd check failed");
`define LND_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lnd check failed");
`else
`define LND_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LND_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/lnd_pkg.sv
// ============================================================================
// Line normal unit package
// Shared item types and the per-bit step of the normalizing root search.
// ============================================================================
package lnd_pkg;

   localparam int RootWidth = 32;
   localparam int RemWidth  = 132;
   localparam int PartWidth = 97;
   localparam int SqWidth   = 65;

   // One component: running remainder T - w^2*sq, partial w*sq, root bits w
   typedef struct packed {
      logic [RemWidth-1:0]  rem;
      logic [PartWidth-1:0] part;
      logic [RootWidth-1:0] root;
   } lnd_lane_type;

   typedef struct packed {
      lnd_lane_type        lane_x;
      lnd_lane_type        lane_y;
      logic [SqWidth-1:0]  sq;
      logic signed [31:0]  first_x;
      logic signed [31:0]  first_y;
      logic                neg_x;
      logic                neg_y;
      logic                degen;
   } lnd_item_type;

   // Try setting root bit idx: (w+b)^2*sq - w^2*sq = 2b*(w*sq) + b^2*sq
   function automatic lnd_lane_type lane_step(lnd_lane_type l, logic [SqWidth-1:0] sq,
                                              int idx);
      lnd_lane_type        r;
      logic [RemWidth-1:0] trial;
      logic [PartWidth-1:0] inc;
      r     = l;
      trial = ({{(RemWidth-PartWidth){1'b0}}, l.part} << (idx + 1))
            + ({{(RemWidth-SqWidth){1'b0}}, sq} << (2 * idx));
      inc   = {{(PartWidth-SqWidth){1'b0}}, sq} << idx;
      if (trial <= l.rem) begin
         r.rem  = l.rem - trial;
         r.part = l.part + inc;
         r.root = l.root | (RootWidth'(1) << idx);
      end
      return r;
   endfunction

endpackage

// File: rtl/core/lnd_cell.sv
// ============================================================================
// Line normal root cell
// Decides one root bit for both normal components and passes the item on.
// ============================================================================
module lnd_cell #(
   parameter int BIT_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_in,
   input  lnd_pkg::lnd_item_type item_in,
   output logic                  valid_out,
   output lnd_pkg::lnd_item_type item_out
);
   import lnd_pkg::*;

   logic         valid_ff;
   lnd_item_type item_ff, item_in_c;

   always_comb begin
      item_in_c        = item_in;
      item_in_c.lane_x = lane_step(item_in.lane_x, item_in.sq, BIT_IDX);
      item_in_c.lane_y = lane_step(item_in.lane_y, item_in.sq, BIT_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;
endmodule

// File: rtl/core/line_normal_and_distance_unit.sv
// ============================================================================
// Line normal and distance unit
// Unit normal of the line through two Q16.16 points and its origin distance.
// ============================================================================
// Usage:
//   req_* carries two points (signed Q16.16). A transfer takes place when
//   req_valid is high and req_stall is low.
//   rsp_* carries the unit normal (signed Q2.30), the distance (signed
//   Q18.16) and a flag for coincident points, whose outputs are all zero.
//   One item is taken every cycle while req_stall is low; the pipeline is
//   3 front stages, a chain of 32 root cells (one result bit each), and 3
//   stages for rounding, the dot product and its rounding.
//   The whole pipeline moves as one while the output register is empty or
//   being taken; when rsp_stall holds a waiting result, everything holds and
//   req_stall is raised in the same cycle.
//   Reset clears all valid bits; the unit is ready right after reset.
// ============================================================================
`include "line_normal_and_distance_unit_macros.svh"

module line_normal_and_distance_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic signed [33:0] rsp_plane_distance,
   output logic               rsp_degenerate
);
   import lnd_pkg::*;

   localparam int NumCells = RootWidth;

   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // ---- stage A: differences and magnitudes
   logic signed [32:0] dx, dy;
   logic               a_valid_ff;
   logic [31:0]        adx_ff, ady_ff;
   logic signed [31:0] a_x1_ff, a_y1_ff;
   logic               a_negx_ff, a_negy_ff, a_degen_ff;

   always_comb begin
      dx = {req_second_x[31], req_second_x} - {req_first_x[31], req_first_x};
      dy = {req_second_y[31], req_second_y} - {req_first_y[31], req_first_y};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         adx_ff     <= dx[32] ? 32'(-dx) : dx[31:0];
         ady_ff     <= dy[32] ? 32'(-dy) : dy[31:0];
         a_x1_ff    <= req_first_x;
         a_y1_ff    <= req_first_y;
         a_negx_ff  <= dy[32];
         a_negy_ff  <= !dx[32] && (dx != 33'sd0);
         a_degen_ff <= (dx == 33'sd0) && (dy == 33'sd0);
      end
   end

   // ---- stage B: squares
   logic               b_valid_ff;
   logic [63:0]        sqx_ff, sqy_ff;
   logic signed [31:0] b_x1_ff, b_y1_ff;
   logic               b_negx_ff, b_negy_ff, b_degen_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff     <= adx_ff * adx_ff;
         sqy_ff     <= ady_ff * ady_ff;
         b_x1_ff    <= a_x1_ff;
         b_y1_ff    <= a_y1_ff;
         b_negx_ff  <= a_negx_ff;
         b_negy_ff  <= a_negy_ff;
         b_degen_ff <= a_degen_ff;
      end
   end

   // ---- stage C: sum of squares and search targets dy^2 * 2^62 (x), dx^2 * 2^62 (y)
   logic         c_valid_ff;
   lnd_item_type c_item_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         c_item_ff.sq          <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
         c_item_ff.lane_x.rem  <= {6'b0, sqy_ff, 62'b0};
         c_item_ff.lane_x.part <= '0;
         c_item_ff.lane_x.root <= '0;
         c_item_ff.lane_y.rem  <= {6'b0, sqx_ff, 62'b0};
         c_item_ff.lane_y.part <= '0;
         c_item_ff.lane_y.root <= '0;
         c_item_ff.first_x     <= b_x1_ff;
         c_item_ff.first_y     <= b_y1_ff;
         c_item_ff.neg_x       <= b_negx_ff;
         c_item_ff.neg_y       <= b_negy_ff;
         c_item_ff.degen       <= b_degen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // ---- root cell chain, most significant bit first
   logic         chain_valid [0:NumCells];
   lnd_item_type chain_item  [0:NumCells];

   assign chain_valid[0] = c_valid_ff;
   assign chain_item[0]  = c_item_ff;

   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      lnd_cell #(
         .BIT_IDX (NumCells - 1 - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (chain_valid[g]),
         .item_in   (chain_item[g]),
         .valid_out (chain_valid[g+1]),
         .item_out  (chain_item[g+1])
      );
   end

   // ---- stage D: round to nearest, apply sign
   lnd_item_type       e_item;
   logic [32:0]        kx, ky;
   logic               d_valid_ff;
   logic signed [31:0] nx_ff, ny_ff, d_x1_ff, d_y1_ff;
   logic               d_degen_ff;

   always_comb begin
      e_item = chain_item[NumCells];
      kx     = ({1'b0, e_item.lane_x.root} + 33'd1) >> 1;
      ky     = ({1'b0, e_item.lane_y.root} + 33'd1) >> 1;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (e_item.degen) begin
            nx_ff <= '0;
            ny_ff <= '0;
         end else begin
            nx_ff <= e_item.neg_x ? -kx[31:0] : kx[31:0];
            ny_ff <= e_item.neg_y ? -ky[31:0] : ky[31:0];
         end
         d_x1_ff    <= e_item.first_x;
         d_y1_ff    <= e_item.first_y;
         d_degen_ff <= e_item.degen;
      end
   end

   // ---- stage E: dot product terms
   logic               f_valid_ff;
   logic signed [63:0] px_ff, py_ff;
   logic signed [31:0] f_nx_ff, f_ny_ff;
   logic               f_degen_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff      <= nx_ff * d_x1_ff;
         py_ff      <= ny_ff * d_y1_ff;
         f_nx_ff    <= nx_ff;
         f_ny_ff    <= ny_ff;
         f_degen_ff <= d_degen_ff;
      end
   end

   // ---- stage F: sum and round Q18.46 to Q18.16, output register
   logic signed [64:0] dot_sum;
   logic [64:0]        dot_mag, dot_rnd;
   logic signed [33:0] plane_dist;

   always_comb begin
      dot_sum    = 65'(px_ff) + 65'(py_ff);
      dot_mag    = dot_sum[64] ? 65'(-dot_sum) : 65'(dot_sum);
      dot_rnd    = (dot_mag + (65'd1 << 29)) >> 30;
      plane_dist = dot_sum[64] ? -dot_rnd[33:0] : dot_rnd[33:0];
   end

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_nx_ff, rsp_ny_ff;
   logic signed [33:0] rsp_dist_ff;
   logic               rsp_degen_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_nx_ff    <= f_nx_ff;
         rsp_ny_ff    <= f_ny_ff;
         rsp_dist_ff  <= f_degen_ff ? '0 : plane_dist;
         rsp_degen_ff <= f_degen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff   <= chain_valid[NumCells];
         f_valid_ff   <= d_valid_ff;
         rsp_valid_ff <= f_valid_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_normal_x       = rsp_nx_ff;
   assign rsp_normal_y       = rsp_ny_ff;
   assign rsp_plane_distance = rsp_dist_ff;
   assign rsp_degenerate     = rsp_degen_ff;

   // ---- checks
   `LND_ASSERT_IMPLIES(a_hold_input, clock, reset, rsp_valid && rsp_stall, req_stall)
   `LND_ASSERT_IMPLIES(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_normal_x == 32'sd0 && rsp_normal_y == 32'sd0 && rsp_plane_distance == 34'sd0)
   `LND_ASSERT_IMPLIES(a_normal_nonzero, clock, reset, rsp_valid && !rsp_degenerate, rsp_normal_x != 32'sd0 || rsp_normal_y != 32'sd0)
   `LND_ASSERT_NEXT(a_stall_keeps, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_plane_distance))
endmodule
